// File: src/hbkd_pkg.sv
// ----------------------------------------------------------------------------
// hbkd_pkg
// Types, usage codes and US layout character tables for the boot keyboard
// report decoder.
// ----------------------------------------------------------------------------
package hbkd_pkg;

	localparam int HELD_DEPTH = 6;
	localparam int KEY_SLOTS_DEFAULT = 6;

	localparam logic [7:0] USAGE_CAPS      = 8'h39;
	localparam logic [7:0] USAGE_A         = 8'h04;
	localparam logic [7:0] USAGE_Z         = 8'h1D;
	localparam logic [7:0] USAGE_SYM_FIRST = 8'h1E;
	localparam logic [7:0] USAGE_SYM_LAST  = 8'h38;
	localparam logic [7:0] SHIFT_MASK      = 8'h22;
	localparam logic [6:0] CHAR_LOWER_A    = 7'h61;
	localparam logic [6:0] CASE_OFFSET     = 7'd32;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
	} report_t;

	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_code;
		logic       caps_state;
	} result_t;

	typedef logic [HELD_DEPTH-1:0][7:0] held_t;

	function automatic logic [6:0] map_sym(logic [4:0] k, logic shift);
		logic [6:0] plain;
		logic [6:0] shifted;
		case (k)
			5'd0:    begin plain = 7'h31; shifted = 7'h21; end
			5'd1:    begin plain = 7'h32; shifted = 7'h40; end
			5'd2:    begin plain = 7'h33; shifted = 7'h23; end
			5'd3:    begin plain = 7'h34; shifted = 7'h24; end
			5'd4:    begin plain = 7'h35; shifted = 7'h25; end
			5'd5:    begin plain = 7'h36; shifted = 7'h5E; end
			5'd6:    begin plain = 7'h37; shifted = 7'h26; end
			5'd7:    begin plain = 7'h38; shifted = 7'h2A; end
			5'd8:    begin plain = 7'h39; shifted = 7'h28; end
			5'd9:    begin plain = 7'h30; shifted = 7'h29; end
			5'd10:   begin plain = 7'h0A; shifted = 7'h0A; end
			5'd12:   begin plain = 7'h08; shifted = 7'h08; end
			5'd13:   begin plain = 7'h09; shifted = 7'h09; end
			5'd14:   begin plain = 7'h20; shifted = 7'h20; end
			5'd15:   begin plain = 7'h2D; shifted = 7'h5F; end
			5'd16:   begin plain = 7'h3D; shifted = 7'h2B; end
			5'd17:   begin plain = 7'h5B; shifted = 7'h7B; end
			5'd18:   begin plain = 7'h5D; shifted = 7'h7D; end
			5'd19:   begin plain = 7'h5C; shifted = 7'h7C; end
			5'd21:   begin plain = 7'h3B; shifted = 7'h3A; end
			5'd22:   begin plain = 7'h27; shifted = 7'h22; end
			5'd23:   begin plain = 7'h60; shifted = 7'h7E; end
			5'd24:   begin plain = 7'h2C; shifted = 7'h3C; end
			5'd25:   begin plain = 7'h2E; shifted = 7'h3E; end
			5'd26:   begin plain = 7'h2F; shifted = 7'h3F; end
			default: begin plain = 7'h00; shifted = 7'h00; end
		endcase
		return shift ? shifted : plain;
	endfunction

	function automatic logic [6:0] map_usage(logic [7:0] u, logic shift, logic caps);
		logic [7:0] ofs;
		logic [6:0] c;
		c = 7'h00;
		ofs = 8'h00;
		if (u inside {[USAGE_A:USAGE_Z]}) begin
			ofs = u - USAGE_A;
			c = CHAR_LOWER_A + ofs[6:0];
			if (shift != caps)
				c = c - CASE_OFFSET;
		end else if (u inside {[USAGE_SYM_FIRST:USAGE_SYM_LAST]}) begin
			ofs = u - USAGE_SYM_FIRST;
			c = map_sym(ofs[4:0], shift);
		end
		return c;
	endfunction

endpackage

// File: src/hbkd_decode.sv
// ----------------------------------------------------------------------------
// hbkd_decode
// Combinational scan of one report against the held keys: new-key test,
// caps toggling, first mapped character and the next held-key image.
// ----------------------------------------------------------------------------
module hbkd_decode #(
	parameter int KEY_SLOTS = hbkd_pkg::KEY_SLOTS_DEFAULT
) (
	input  hbkd_pkg::report_t report,
	input  hbkd_pkg::held_t   held,
	input  logic              caps,
	output hbkd_pkg::result_t result,
	output hbkd_pkg::held_t   held_next
);

	hbkd_pkg::held_t                 slots;
	logic [hbkd_pkg::HELD_DEPTH-1:0] is_new;
	logic [hbkd_pkg::HELD_DEPTH-1:0][6:0] mapped;
	logic       shift;
	logic       found;
	logic       toggled;
	logic       caps_n;
	logic [6:0] ch;

	always_comb begin
		slots[0] = report.key_slot_0;
		slots[1] = report.key_slot_1;
		slots[2] = report.key_slot_2;
		slots[3] = report.key_slot_3;
		slots[4] = report.key_slot_4;
		slots[5] = report.key_slot_5;
		for (int i = 0; i < hbkd_pkg::HELD_DEPTH; i++) begin
			if (i >= KEY_SLOTS)
				slots[i] = 8'h00;
		end
	end

	assign shift = |(report.modifier_bits & hbkd_pkg::SHIFT_MASK);

	always_comb begin
		for (int i = 0; i < hbkd_pkg::HELD_DEPTH; i++) begin
			is_new[i] = (slots[i] != 8'h00);
			for (int j = 0; j < hbkd_pkg::HELD_DEPTH; j++) begin
				if (j < KEY_SLOTS && held[j] == slots[i])
					is_new[i] = 1'b0;
			end
			mapped[i] = hbkd_pkg::map_usage(slots[i], shift, caps);
		end
	end

	always_comb begin
		found = 1'b0;
		toggled = 1'b0;
		caps_n = caps;
		ch = 7'h00;
		for (int i = 0; i < hbkd_pkg::HELD_DEPTH; i++) begin
			if (i < KEY_SLOTS && !found && is_new[i]) begin
				if (slots[i] == hbkd_pkg::USAGE_CAPS) begin
					caps_n = ~caps_n;
					toggled = 1'b1;
				end else if (mapped[i] != 7'h00) begin
					ch = mapped[i];
					found = 1'b1;
				end
			end
		end
	end

	assign result.char_valid = found && !toggled;
	assign result.char_code  = toggled ? 7'h00 : ch;
	assign result.caps_state = caps_n;
	assign held_next         = slots;

endmodule

// File: src/hid_boot_keyboard_report_decoder_unit.sv
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_decoder_unit
// Boot keyboard report to US ASCII decoder with held-key and caps tracking.
// ----------------------------------------------------------------------------
// Input channel report_valid / report_stall / report carries one boot report
// word: modifier byte and six key usages. Output channel result_valid /
// result_stall / result carries one word per report: char_valid, char_code
// and caps_state. A word moves when valid is high and stall is low.
// The report lands in the input register when it is accepted, passes the
// decode logic and lands in the result register once that register can
// advance, and from there it moves out as a result word.
// Throughput is one report per cycle while the result channel does not
// stall, limited only by the single decode stage between the two registers;
// held keys and the caps flag update as a report moves into the result
// register, so the next report sees them in the following cycle.
// Reset clears the held keys, the caps flag and both stage valids.
// A stalled result holds in place; the input register keeps its report and
// report_stall rises until the result register frees up.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_report_decoder_unit #(
	parameter int KEY_SLOTS = hbkd_pkg::KEY_SLOTS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              report_valid,
	output logic              report_stall,
	input  hbkd_pkg::report_t report,
	output logic              result_valid,
	input  logic              result_stall,
	output hbkd_pkg::result_t result
);

	hbkd_pkg::report_t report_s1;
	logic              valid_s1;
	hbkd_pkg::result_t result_s2;
	logic              valid_s2;
	hbkd_pkg::held_t   held_q;
	logic              caps_q;

	hbkd_pkg::result_t dec_result;
	hbkd_pkg::held_t   dec_held;
	logic              advance;
	logic              take;

	assign advance      = !valid_s2 || !result_stall;
	assign report_stall = valid_s1 && !advance;
	assign take         = report_valid && !report_stall;

	hbkd_decode #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_decode (
		.report   (report_s1),
		.held     (held_q),
		.caps     (caps_q),
		.result   (dec_result),
		.held_next(dec_held)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			held_q   <= '0;
			caps_q   <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= valid_s1;
			if (advance && valid_s1) begin
				held_q <= dec_held;
				caps_q <= dec_result.caps_state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			report_s1 <= report;
		if (advance && valid_s1)
			result_s2 <= dec_result;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// File: tb/hid_boot_keyboard_report_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_decoder_unit_tb
// Sends boot keyboard reports through the decoder while both channels idle
// and stall at random. A directed table covers the corner cases first. Keyed
// sequences with random content follow, mixed with noise reports. Every
// result word is checked against the expected word of its directed row where
// given, else against a predictor tracking the held keys and caps lock flag.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_report_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REPORTS = 1425;
	localparam int QUIET_FIRST = 500;
	localparam int QUIET_LAST = 800;
	localparam int DRAIN_AT = 1000;
	localparam int STUCK_LIMIT = 1000;
	localparam int TAIL_CYCLES = 6;
	localparam int SHOWN_MISMATCHES = 10;

	// usages 0x1E..0x38, zero where the key types nothing
	localparam logic [0:26][6:0] PLAIN_SYMS = {
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
		7'h0A, 7'h00, 7'h08, 7'h09, 7'h20, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C,
		7'h00, 7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F
	};
	localparam logic [0:26][6:0] SHIFTED_SYMS = {
		7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
		7'h0A, 7'h00, 7'h08, 7'h09, 7'h20, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C,
		7'h00, 7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F
	};

	typedef struct {
		hbkd_pkg::report_t rep;
		bit                typed;
		hbkd_pkg::result_t want;
	} table_row_t;

	logic              clk;
	logic              arst_n;
	logic              report_valid;
	logic              report_stall;
	hbkd_pkg::report_t report;
	logic              result_valid;
	logic              result_stall;
	hbkd_pkg::result_t result;

	logic [0:hbkd_pkg::HELD_DEPTH-1][7:0] held_usages = '0;
	logic                                 caps_on = 1'b0;
	hbkd_pkg::report_t                    prev_report = '0;
	hbkd_pkg::result_t                    pending_chars[$];
	table_row_t                           directed_rows[$];
	int                                   mismatches = 0;
	bit                                   no_gaps = 1'b0;

	hid_boot_keyboard_report_decoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [6:0] usage_to_ascii(input logic [7:0] u, input logic shift,
			input logic caps);
		logic [6:0] letter;
		logic [7:0] idx;
		letter = 7'h00;
		idx = 8'h00;
		if (u >= hbkd_pkg::USAGE_A && u <= hbkd_pkg::USAGE_Z) begin
			letter = u[6:0] - hbkd_pkg::USAGE_A[6:0] + 7'h61;
			if (shift ^ caps)
				letter = letter - 7'd32;
		end else if (u >= hbkd_pkg::USAGE_SYM_FIRST && u <= hbkd_pkg::USAGE_SYM_LAST) begin
			idx = u - hbkd_pkg::USAGE_SYM_FIRST;
			letter = shift ? SHIFTED_SYMS[idx[4:0]] : PLAIN_SYMS[idx[4:0]];
		end
		return letter;
	endfunction

	function automatic hbkd_pkg::result_t decode_report(input hbkd_pkg::report_t r);
		logic [0:hbkd_pkg::HELD_DEPTH-1][7:0] keys;
		logic                                 shift;
		logic                                 toggled;
		logic                                 picked;
		logic                                 fresh;
		logic [6:0]                           ch;
		hbkd_pkg::result_t                    res;
		keys = {r.key_slot_0, r.key_slot_1, r.key_slot_2,
			r.key_slot_3, r.key_slot_4, r.key_slot_5};
		shift = |(r.modifier_bits & hbkd_pkg::SHIFT_MASK);
		toggled = 1'b0;
		picked = 1'b0;
		ch = 7'h00;
		for (int i = 0; i < hbkd_pkg::HELD_DEPTH; i++) begin
			if (!picked && keys[i] != 8'h00) begin
				fresh = 1'b1;
				for (int j = 0; j < hbkd_pkg::HELD_DEPTH; j++)
					if (held_usages[j] == keys[i])
						fresh = 1'b0;
				if (fresh) begin
					if (keys[i] == hbkd_pkg::USAGE_CAPS) begin
						caps_on = !caps_on;
						toggled = 1'b1;
					end else begin
						ch = usage_to_ascii(keys[i], shift, caps_on);
						picked = (ch != 7'h00);
					end
				end
			end
		end
		held_usages = keys;
		if (toggled)
			ch = 7'h00;
		res.char_valid = (ch != 7'h00);
		res.char_code = ch;
		res.caps_state = caps_on;
		return res;
	endfunction

	function automatic hbkd_pkg::report_t random_report();
		hbkd_pkg::report_t                    r;
		logic [0:hbkd_pkg::HELD_DEPTH-1][7:0] keys;
		int                                   roll;
		int                                   idx;
		r = prev_report;
		keys = {r.key_slot_0, r.key_slot_1, r.key_slot_2,
			r.key_slot_3, r.key_slot_4, r.key_slot_5};
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			r.modifier_bits = 8'($urandom_range(0, 255));
			for (int i = 0; i < hbkd_pkg::HELD_DEPTH; i++)
				keys[i] = 8'($urandom_range(0, 255));
		end else begin
			repeat ($urandom_range(1, 3)) begin
				idx = $urandom_range(0, hbkd_pkg::HELD_DEPTH - 1);
				roll = $urandom_range(0, 99);
				if (roll < 35)
					keys[idx] = 8'h00;
				else if (roll < 42)
					keys[idx] = hbkd_pkg::USAGE_CAPS;
				else if (roll < 90)
					keys[idx] = 8'($urandom_range(hbkd_pkg::USAGE_A,
						hbkd_pkg::USAGE_SYM_LAST));
				else
					keys[idx] = 8'($urandom_range(0, 255));
			end
			roll = $urandom_range(0, 99);
			if (roll < 45)
				r.modifier_bits = 8'h00;
			else if (roll < 60)
				r.modifier_bits = 8'h02;
			else if (roll < 75)
				r.modifier_bits = 8'h20;
			else
				r.modifier_bits = 8'($urandom_range(0, 255));
		end
		{r.key_slot_0, r.key_slot_1, r.key_slot_2,
			r.key_slot_3, r.key_slot_4, r.key_slot_5} = keys;
		prev_report = r;
		return r;
	endfunction

	function automatic void add_report(input logic [7:0] m, s0, s1, s2, s3, s4, s5,
			input bit typed, input hbkd_pkg::result_t want);
		table_row_t row;
		row.rep = {m, s0, s1, s2, s3, s4, s5};
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	function automatic void flag_mismatch(input string what, input hbkd_pkg::result_t want,
			input hbkd_pkg::result_t got);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES)
			$display("%s: expected valid=%0b code=%02h caps=%0b, got valid=%0b code=%02h caps=%0b",
				what, want.char_valid, want.char_code, want.caps_state,
				got.char_valid, got.char_code, got.caps_state);
	endfunction

	task automatic offer_report(input hbkd_pkg::report_t r, input bit typed,
			input hbkd_pkg::result_t want);
		hbkd_pkg::result_t predicted;
		while (!no_gaps && $urandom_range(0, 99) < 30) begin
			report_valid <= 1'b0;
			@(negedge clk);
		end
		report <= r;
		report_valid <= 1'b1;
		@(posedge clk);
		while (report_stall)
			@(posedge clk);
		predicted = decode_report(r);
		pending_chars.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	initial begin
		result_stall <= 1'b0;
		forever begin
			@(negedge clk);
			result_stall <= !no_gaps && ($urandom_range(0, 99) < 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_chars.size() == 0) begin
				flag_mismatch("unexpected word", '0, result);
			end else if (result.char_valid !== pending_chars[0].char_valid
					|| result.char_code !== pending_chars[0].char_code
					|| result.caps_state !== pending_chars[0].caps_state) begin
				flag_mismatch("mismatch", pending_chars[0], result);
				void'(pending_chars.pop_front());
			end else begin
				void'(pending_chars.pop_front());
			end
		end
	end

	initial begin
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((report_valid && !report_stall) || (result_valid && !result_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("hid_boot_keyboard_report_decoder_unit_tb: errors");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		report_valid <= 1'b0;
		report <= '0;

		add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, {1'b0, 7'h00, 1'b0});
		add_report(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, {1'b1, 7'h61, 1'b0});
		add_report(8'h22, 8'h04, 8'h16, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, {1'b0, 7'h00, 1'b0});
		add_report(8'h02, 8'h1D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, {1'b1, 7'h5A, 1'b0});
		add_report(8'h20, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'h00, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, {1'b0, 7'h00, 1'b1});
		add_report(8'h00, 8'h39, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		// two fresh caps keys cancel, output still dropped
		add_report(8'h00, 8'h39, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, {1'b0, 7'h00, 1'b1});
		add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		// caps behind the picked key is never reached
		add_report(8'h00, 8'h05, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		// caps ahead of the picked key drops the character
		add_report(8'h00, 8'h39, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, {1'b0, 7'h00, 1'b0});
		add_report(8'h00, 8'h29, 8'h32, 8'h3A, 8'h07, 8'h08, 8'h00, 1'b0, '0);
		add_report(8'h22, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'h02, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'h20, 8'h2C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'h20, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'hDD, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 1'b0, '0);
		add_report(8'h00, 8'h7F, 8'h80, 8'h01, 8'h02, 8'h03, 8'h55, 1'b0, '0);
		add_report(8'h00, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		add_report(8'h22, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			offer_report(directed_rows[k].rep, directed_rows[k].typed, directed_rows[k].want);

		for (int n = 0; n < RANDOM_REPORTS; n++) begin
			if (n == QUIET_FIRST)
				no_gaps = 1'b1;
			if (n == QUIET_LAST)
				no_gaps = 1'b0;
			if (n == DRAIN_AT) begin
				// hold off until every result word is back
				report_valid <= 1'b0;
				while (pending_chars.size() != 0)
					@(posedge clk);
				@(negedge clk);
			end
			offer_report(random_report(), 1'b0, '0);
		end
		report_valid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			mismatches++;
			$display("%0d result words never arrived", pending_chars.size());
		end
		if (mismatches == 0)
			$display("hid_boot_keyboard_report_decoder_unit_tb: clean");
		else
			$display("hid_boot_keyboard_report_decoder_unit_tb: errors");
		$finish;
	end

endmodule
